// ----- hdl/qhd_pkg.sv -----
// Shared types, character codes and helpers for the quoted hex-escape decoder.
// No dependencies; imported by qhd_decode, qhd_emit, the top level and the testbench.
package qhd_pkg;

	localparam int SPACE_W = 5;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_F = 8'h66;

	// escape prefix progress
	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_BSLASH = 2'd1;
	localparam logic [1:0] ESC_X = 2'd2;
	localparam logic [1:0] ESC_DIGIT = 2'd3;

	// one decoded hex digit
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
		logic       low;
	} hex_t;

	// results caused by one input byte, in emission order:
	// broken prefix, quote, spaces, literal byte, trailing prefix, end marker.
	// Prefix masks: bit 0 backslash, bit 1 x, bit 2 held hex digit.
	typedef struct packed {
		logic [2:0]         pa;
		logic [3:0]         pa_nib;
		logic               pa_low;
		logic               quote;
		logic [SPACE_W-1:0] spaces;
		logic               lit;
		logic [7:0]         lit_byte;
		logic [2:0]         pb;
		logic [3:0]         pb_nib;
		logic               pb_low;
		logic               mark;
		logic               last;
	} job_t;

	// decoder state seen from outside
	typedef struct packed {
		logic               at_start;
		logic               clean;
		logic [SPACE_W-1:0] spaces;
	} dec_status_t;

	// emitter occupancy
	typedef struct packed {
		logic busy;
		logic out_full;
	} emit_status_t;

	function automatic hex_t hex_value(input logic [7:0] b);
		hex_t h;
		h = '0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			h.ok = 1'b1;
			h.val = 4'(b - CH_ZERO);
		end else if (b >= CH_UP_A && b <= CH_UP_F) begin
			h.ok = 1'b1;
			h.val = 4'(b - CH_UP_A + 8'd10);
		end else if (b >= CH_LO_A && b <= CH_LO_F) begin
			h.ok = 1'b1;
			h.val = 4'(b - CH_LO_A + 8'd10);
			h.low = 1'b1;
		end
		return h;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input logic low);
		logic [7:0] r;
		if (v < 4'd10) r = CH_ZERO + {4'h0, v};
		else r = (low ? CH_LO_A : CH_UP_A) + {4'h0, v} - 8'd10;
		return r;
	endfunction

	function automatic logic prefix_mask_bit(input logic [1:0] stage, input logic [1:0] pos);
		return stage > pos;
	endfunction

	function automatic logic [2:0] prefix_mask(input logic [1:0] stage);
		return {prefix_mask_bit(stage, 2'd2), prefix_mask_bit(stage, 2'd1),
			prefix_mask_bit(stage, 2'd0)};
	endfunction

	function automatic logic job_empty(input job_t j);
		return j.pa == 3'b000 && !j.quote && j.spaces == '0 && !j.lit &&
			j.pb == 3'b000 && !j.mark;
	endfunction

endpackage

// ----- hdl/qhd_decode.sv -----
// Decoder state and per-byte decision: builds the result job for one input byte.
// Depends on qhd_pkg.
module qhd_decode import qhd_pkg::*; #(
	parameter int MAX_HELD_SPACES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output job_t        job,
	output dec_status_t status
);

	logic               at_start_q;
	logic [1:0]         esc_q;
	logic [3:0]         nib_q;
	logic               low_q;
	logic               quote_q;
	logic [SPACE_W-1:0] spaces_q;

	logic               at_start_d;
	logic [1:0]         esc_d;
	logic [3:0]         nib_d;
	logic               low_d;
	logic               quote_d;
	logic [SPACE_W-1:0] spaces_d;
	hex_t               hx;
	logic               consumed;

	// decide results and next state for the presented byte
	always_comb begin
		hx = hex_value(in_byte);
		job = '0;
		at_start_d = 1'b0;
		esc_d = esc_q;
		nib_d = nib_q;
		low_d = low_q;
		quote_d = quote_q;
		spaces_d = spaces_q;
		consumed = (esc_q == ESC_BSLASH && in_byte == CH_X) ||
			(esc_q == ESC_X && hx.ok) || (esc_q == ESC_DIGIT && hx.ok);

		if (at_start_q && in_byte == CH_QUOTE) begin
			// drop the opening quote
		end else if (consumed) begin
			unique case (esc_q)
				ESC_BSLASH: esc_d = ESC_X;
				ESC_X: begin
					esc_d = ESC_DIGIT;
					nib_d = hx.val;
					low_d = hx.low;
				end
				default: begin
					job.lit = 1'b1;
					job.lit_byte = {nib_q, hx.val};
					esc_d = ESC_NONE;
					nib_d = 4'h0;
					low_d = 1'b0;
				end
			endcase
		end else begin
			// flush a broken prefix, then treat the byte as plain text
			job.pa = prefix_mask(esc_q);
			job.pa_nib = nib_q;
			job.pa_low = low_q;
			esc_d = ESC_NONE;
			if (in_byte == CH_SPACE) begin
				if (spaces_q >= SPACE_W'(MAX_HELD_SPACES)) begin
					job.quote = quote_q;
					job.spaces = spaces_q;
					quote_d = 1'b0;
					spaces_d = SPACE_W'(1);
				end else begin
					spaces_d = spaces_q + SPACE_W'(1);
				end
			end else begin
				job.quote = quote_q;
				job.spaces = spaces_q;
				quote_d = 1'b0;
				spaces_d = '0;
				if (in_byte == CH_QUOTE) begin
					quote_d = 1'b1;
				end else if (in_byte == CH_BSLASH) begin
					esc_d = ESC_BSLASH;
				end else begin
					job.lit = 1'b1;
					job.lit_byte = in_byte;
				end
			end
		end

		// end of value: flush the prefix, drop trailing quote and spaces
		if (in_last) begin
			job.pb = prefix_mask(esc_d);
			job.pb_nib = nib_d;
			job.pb_low = low_d;
			job.last = 1'b1;
			job.mark = job_empty(job);
			at_start_d = 1'b1;
			esc_d = ESC_NONE;
			nib_d = 4'h0;
			low_d = 1'b0;
			quote_d = 1'b0;
			spaces_d = '0;
		end
	end

	// advance state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			esc_q <= ESC_NONE;
			nib_q <= 4'h0;
			low_q <= 1'b0;
			quote_q <= 1'b0;
			spaces_q <= '0;
		end else if (take) begin
			at_start_q <= at_start_d;
			esc_q <= esc_d;
			nib_q <= nib_d;
			low_q <= low_d;
			quote_q <= quote_d;
			spaces_q <= spaces_d;
		end
	end

	assign status.at_start = at_start_q;
	assign status.clean = esc_q == ESC_NONE && !quote_q && spaces_q == '0;
	assign status.spaces = spaces_q;

endmodule

// ----- hdl/qhd_emit.sv -----
// Job register and output register: drains one job as a run of result bytes.
// Depends on qhd_pkg.
module qhd_emit import qhd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  job_t         job_in,
	output logic         slot_free,
	output emit_status_t status,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_byte,
	output logic         byte_valid,
	output logic         out_last
);

	job_t       job_s1;
	logic       job_vld_q;
	job_t       nxt;
	logic [7:0] item_byte;
	logic       item_vld;
	logic       rest_empty;
	logic       adv;
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       byte_vld_q;
	logic       out_last_q;

	assign adv = !out_vld_q || out_ready;

	// pick the next result of the held job and strip it off
	always_comb begin
		nxt = job_s1;
		item_byte = 8'h00;
		item_vld = 1'b1;
		priority if (job_s1.pa[0]) begin
			item_byte = CH_BSLASH;
			nxt.pa[0] = 1'b0;
		end else if (job_s1.pa[1]) begin
			item_byte = CH_X;
			nxt.pa[1] = 1'b0;
		end else if (job_s1.pa[2]) begin
			item_byte = hex_char(job_s1.pa_nib, job_s1.pa_low);
			nxt.pa[2] = 1'b0;
		end else if (job_s1.quote) begin
			item_byte = CH_QUOTE;
			nxt.quote = 1'b0;
		end else if (job_s1.spaces != '0) begin
			item_byte = CH_SPACE;
			nxt.spaces = job_s1.spaces - SPACE_W'(1);
		end else if (job_s1.lit) begin
			item_byte = job_s1.lit_byte;
			nxt.lit = 1'b0;
		end else if (job_s1.pb[0]) begin
			item_byte = CH_BSLASH;
			nxt.pb[0] = 1'b0;
		end else if (job_s1.pb[1]) begin
			item_byte = CH_X;
			nxt.pb[1] = 1'b0;
		end else if (job_s1.pb[2]) begin
			item_byte = hex_char(job_s1.pb_nib, job_s1.pb_low);
			nxt.pb[2] = 1'b0;
		end else begin
			// bare end marker
			item_vld = 1'b0;
			nxt.mark = 1'b0;
		end
		rest_empty = job_empty(nxt);
	end

	assign slot_free = !job_vld_q || (adv && rest_empty);

	// control: job occupancy and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) out_vld_q <= job_vld_q;
			if (load) job_vld_q <= 1'b1;
			else if (job_vld_q && adv && rest_empty) job_vld_q <= 1'b0;
		end
	end

	// payload: job contents and output byte
	always_ff @(posedge clk) begin
		if (adv && job_vld_q) begin
			out_byte_q <= item_byte;
			byte_vld_q <= item_vld;
			out_last_q <= job_s1.last && rest_empty;
		end
		if (load) job_s1 <= job_in;
		else if (adv && job_vld_q) job_s1 <= nxt;
	end

	assign out_valid = out_vld_q;
	assign out_byte = out_byte_q;
	assign byte_valid = byte_vld_q;
	assign out_last = out_last_q;
	assign status.busy = job_vld_q;
	assign status.out_full = out_vld_q;

endmodule

// ----- hdl/quoted_hex_escape_decoder.sv -----
// Top level of the quoted hex-escape decoder: decoder state plus result emitter.
// Depends on qhd_pkg, qhd_decode and qhd_emit.
//
// Decodes a quoted text value fed one byte per transfer, in_last on its final byte.
// An opening quote is dropped, a closing quote followed only by spaces is dropped
// with those spaces, and each backslash-x-hex-hex sequence becomes one byte; broken
// sequences pass through literally. Every input byte is decided in the cycle it is
// accepted. Unless the output stalls, bytes that yield at most one result are taken
// at one byte per cycle, and the single job register drains one result per cycle into
// the output register. A byte releasing held bytes (a quote and up to MAX_HELD_SPACES
// spaces before it, or a broken escape prefix) yields up to MAX_HELD_SPACES+2 results
// and holds off input until they drain. Bytes that yield nothing (held spaces, quotes,
// escape prefixes) are absorbed without touching the job register. A value that
// yields no byte at all ends with a bare marker (byte_valid low).
module quoted_hex_escape_decoder import qhd_pkg::*; #(
	parameter int MAX_HELD_SPACES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       out_last
);

	logic         take;
	job_t         job;
	dec_status_t  dec_st;
	emit_status_t emit_st;
	logic         slot_free;

	assign in_ready = slot_free;
	assign take = in_valid && in_ready;

	qhd_decode #(
		.MAX_HELD_SPACES(MAX_HELD_SPACES)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.in_byte(in_byte),
		.in_last(in_last),
		.job(job),
		.status(dec_st)
	);

	// queue only transfers that produce at least one result
	qhd_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load(take && !job_empty(job)),
		.job_in(job),
		.slot_free(slot_free),
		.status(emit_st),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.out_last(out_last)
	);

	// an empty job slot always takes input
	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!emit_st.busy |-> in_ready)
		else $error("input stalled with no pending job");

	// a bare end marker closes a value
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_last)
		else $error("end marker without last flag");

	// the end of a value returns the decoder to its start state
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_last |=> dec_st.at_start && dec_st.clean)
		else $error("state not cleared after last byte");

	// held space count stays within its limit
	a_space_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dec_st.spaces <= SPACE_W'(MAX_HELD_SPACES))
		else $error("held spaces exceed limit");

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		emit_st.out_full && !out_ready |=> emit_st.out_full && $stable(out_byte) &&
			$stable(byte_valid) && $stable(out_last))
		else $error("result changed while stalled");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the quoted hex-escape decoder; a built-in predictor or a
// directed row gives each expected result. Depends on qhd_pkg and quoted_hex_escape_decoder.
module testbench;
	import qhd_pkg::*;

	localparam int HELD_SPACE_LIMIT = 16;
	localparam int N_DIRECTED = 25;
	localparam int RANDOM_PER_PHASE = 145;
	localparam int DRAIN_CYCLES = 24;

	// one decoded result
	typedef struct packed {
		logic [7:0] ch;
		logic       has_byte;
		logic       fin;
	} dec_out_t;

	// how the expected results of a stimulus row are obtained
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_ONE
	} row_kind_e;

	// one input byte plus the way it is checked
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		row_kind_e  kind;
		dec_out_t   want;
	} feed_row_t;

	// directed rows: extremes, lone marker, escapes, broken escapes, held quote and spaces
	localparam feed_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h41,     1'b1, ROW_ONE,     '{8'h41, 1'b1, 1'b1}},
		'{CH_QUOTE,  1'b1, ROW_ONE,     '{8'h00, 1'b0, 1'b1}},
		'{8'h00,     1'b1, ROW_ONE,     '{8'h00, 1'b1, 1'b1}},
		'{8'hFF,     1'b1, ROW_ONE,     '{8'hFF, 1'b1, 1'b1}},
		'{CH_BSLASH, 1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{CH_X,      1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{8'h34,     1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{8'h61,     1'b1, ROW_ONE,     '{8'h4A, 1'b1, 1'b1}},
		'{CH_QUOTE,  1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{CH_BSLASH, 1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{CH_X,      1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{8'h66,     1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{8'h47,     1'b0, ROW_PREDICT, '{8'h00, 1'b0, 1'b0}},
		'{CH_QUOTE,  1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{CH_SPACE,  1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{CH_SPACE,  1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{8'h7A,     1'b0, ROW_PREDICT, '{8'h00, 1'b0, 1'b0}},
		'{CH_BSLASH, 1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{CH_BSLASH, 1'b0, ROW_PREDICT, '{8'h00, 1'b0, 1'b0}},
		'{CH_X,      1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{8'h44,     1'b1, ROW_PREDICT, '{8'h00, 1'b0, 1'b0}},
		'{8'h71,     1'b0, ROW_PREDICT, '{8'h00, 1'b0, 1'b0}},
		'{CH_QUOTE,  1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{CH_SPACE,  1'b0, ROW_SILENT,  '{8'h00, 1'b0, 1'b0}},
		'{CH_SPACE,  1'b1, ROW_ONE,     '{8'h00, 1'b0, 1'b1}}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       out_last;

	feed_row_t stim_q[$];
	dec_out_t  want_q[$];
	dec_out_t  step_q[$];
	feed_row_t cur_row;
	bit        in_taken;
	int        tx_idle_pct;
	int        rx_idle_pct;
	int        n_planned;
	int        n_accepted;
	int        n_values;
	int        n_checked;
	int        n_errors;

	// predictor state
	logic       pr_at_start;
	logic [1:0] pr_stage;
	logic [3:0] pr_nib;
	logic       pr_low;
	logic       pr_quote;
	logic [4:0] pr_spaces;

	quoted_hex_escape_decoder #(
		.MAX_HELD_SPACES(HELD_SPACE_LIMIT)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_UP_A && b <= CH_UP_F) ||
			(b >= CH_LO_A && b <= CH_LO_F);
	endfunction

	function automatic logic [3:0] digit_val(input logic [7:0] b);
		logic [7:0] v;
		if (b <= CH_NINE) v = b - CH_ZERO;
		else if (b <= CH_UP_F) v = b - CH_UP_A + 8'd10;
		else v = b - CH_LO_A + 8'd10;
		return v[3:0];
	endfunction

	// replay a held digit in the case it came in
	function automatic logic [7:0] nib_to_char(input logic [3:0] v, input logic low);
		if (v < 4'd10) return CH_ZERO + {4'h0, v};
		return (low ? CH_LO_A : CH_UP_A) + {4'h0, v} - 8'd10;
	endfunction

	task automatic note_byte(input logic [7:0] b);
		step_q.push_back('{b, 1'b1, 1'b0});
	endtask

	// release a held quote and spaces as interior bytes
	task automatic flush_trailing();
		int k;
		if (pr_quote) note_byte(CH_QUOTE);
		for (k = 0; k < int'(pr_spaces); k++) note_byte(CH_SPACE);
		pr_quote = 1'b0;
		pr_spaces = '0;
	endtask

	// emit a broken escape prefix literally
	task automatic flush_prefix();
		if (pr_stage != ESC_NONE) note_byte(CH_BSLASH);
		if (pr_stage == ESC_X || pr_stage == ESC_DIGIT) note_byte(CH_X);
		if (pr_stage == ESC_DIGIT) note_byte(nib_to_char(pr_nib, pr_low));
		pr_stage = ESC_NONE;
	endtask

	task automatic take_plain(input logic [7:0] b);
		if (b == CH_SPACE) begin
			if (int'(pr_spaces) >= HELD_SPACE_LIMIT) flush_trailing();
			pr_spaces = pr_spaces + 5'd1;
		end else if (b == CH_QUOTE) begin
			flush_trailing();
			pr_quote = 1'b1;
		end else if (b == CH_BSLASH) begin
			flush_trailing();
			pr_stage = ESC_BSLASH;
		end else begin
			flush_trailing();
			note_byte(b);
		end
	endtask

	task automatic take_escaped(input logic [7:0] b);
		if (pr_stage == ESC_BSLASH && b == CH_X) begin
			pr_stage = ESC_X;
		end else if (pr_stage == ESC_X && is_digit(b)) begin
			pr_nib = digit_val(b);
			pr_low = (b >= CH_LO_A);
			pr_stage = ESC_DIGIT;
		end else if (pr_stage == ESC_DIGIT && is_digit(b)) begin
			note_byte({pr_nib, digit_val(b)});
			pr_stage = ESC_NONE;
			pr_nib = '0;
			pr_low = 1'b0;
		end else begin
			flush_prefix();
			take_plain(b);
		end
	endtask

	task automatic clear_decoder();
		pr_at_start = 1'b1;
		pr_stage = ESC_NONE;
		pr_nib = '0;
		pr_low = 1'b0;
		pr_quote = 1'b0;
		pr_spaces = '0;
	endtask

	// work out the results of one accepted byte into step_q
	task automatic predict_transfer(input logic [7:0] b, input logic fin);
		dec_out_t tail;
		step_q.delete();
		if (pr_at_start) begin
			pr_at_start = 1'b0;
			if (b != CH_QUOTE) take_escaped(b);
		end else begin
			take_escaped(b);
		end
		if (fin) begin
			flush_prefix();
			pr_quote = 1'b0;
			pr_spaces = '0;
			if (step_q.size() == 0) step_q.push_back('{8'h00, 1'b0, 1'b0});
			tail = step_q.pop_back();
			tail.fin = 1'b1;
			step_q.push_back(tail);
			clear_decoder();
		end
	endtask

	// ---------------- stimulus ----------------

	function automatic logic [7:0] pick_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
	endfunction

	task automatic push_spaces(ref logic [7:0] val_q[$], input int n);
		repeat (n) val_q.push_back(CH_SPACE);
	endtask

	// build whole values from escapes, quotes, spaces, broken escapes and plain bytes, until the budget is met
	task automatic queue_random_values(input int budget);
		logic [7:0] val_q[$];
		feed_row_t  row;
		int         added;
		int         pieces;
		int         pick;
		int         k;
		int         j;
		added = 0;
		while (added < budget) begin
			val_q.delete();
			if ($urandom_range(0, 99) < 60) val_q.push_back(CH_QUOTE);
			pieces = $urandom_range(1, 6);
			for (k = 0; k < pieces; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					val_q.push_back(CH_BSLASH);
					val_q.push_back(CH_X);
					val_q.push_back(pick_hex_char());
					val_q.push_back(pick_hex_char());
				end else if (pick < 40) begin
					val_q.push_back(CH_QUOTE);
					push_spaces(val_q, $urandom_range(0, 4));
				end else if (pick < 47) begin
					// long run: can cross the held-space limit
					if ($urandom_range(0, 1)) val_q.push_back(CH_QUOTE);
					push_spaces(val_q, $urandom_range(14, 20));
				end else if (pick < 60) begin
					// escape prefix with a random breaker, which mostly breaks it
					val_q.push_back(CH_BSLASH);
					if ($urandom_range(0, 2) != 0) begin
						val_q.push_back(CH_X);
						if ($urandom_range(0, 1)) val_q.push_back(pick_hex_char());
					end
					case ($urandom_range(0, 4))
						0: val_q.push_back(CH_BSLASH);
						1: val_q.push_back(CH_QUOTE);
						2: val_q.push_back(CH_SPACE);
						default: val_q.push_back(8'($urandom_range(0, 255)));
					endcase
				end else if (pick < 90) begin
					val_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					val_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
				end
			end
			// closing quote and trailing spaces
			if ($urandom_range(0, 1)) begin
				val_q.push_back(CH_QUOTE);
				push_spaces(val_q, $urandom_range(0, 3));
			end
			for (j = 0; j < val_q.size(); j++) begin
				row.ch = val_q[j];
				row.fin = (j == val_q.size() - 1);
				row.kind = ROW_PREDICT;
				row.want = '0;
				stim_q.push_back(row);
				added++;
			end
		end
		n_planned += added;
	endtask

	// ---------------- drivers ----------------

	// present the next byte once the previous one has transferred
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (stim_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				cur_row = stim_q.pop_front();
				in_valid <= 1'b1;
				in_byte <= cur_row.ch;
				in_last <= cur_row.fin;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		dec_out_t got;
		dec_out_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (arst_n) begin
			// check a result transfer against the oldest expectation
			if (out_valid && out_ready) begin
				got = '{out_byte, byte_valid, out_last};
				if (want_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result: byte %h valid %b last %b",
							out_byte, byte_valid, out_last);
				end else begin
					want = want_q.pop_front();
					n_checked++;
					if (got != want) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch #%0d: want byte %h valid %b last %b, got %h %b %b",
								n_checked, want.ch, want.has_byte, want.fin,
								got.ch, got.has_byte, got.fin);
					end
				end
			end
			// predict the results of an input transfer
			if (in_valid && in_ready) begin
				n_accepted++;
				if (cur_row.fin) n_values++;
				predict_transfer(cur_row.ch, cur_row.fin);
				if (cur_row.kind == ROW_PREDICT) begin
					foreach (step_q[k]) want_q.push_back(step_q[k]);
				end else if (cur_row.kind == ROW_ONE) begin
					want_q.push_back(cur_row.want);
				end
			end
		end
	end

	// ---------------- sequence ----------------

	task automatic run_phase(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		queue_random_values(RANDOM_PER_PHASE);
		while (n_accepted != n_planned) @(negedge clk);
	endtask

	initial begin
		int k;
		in_valid = 1'b0;
		in_byte = 8'h00;
		in_last = 1'b0;
		out_ready = 1'b0;
		tx_idle_pct = 23;
		rx_idle_pct = 64;
		n_planned = 0;
		n_accepted = 0;
		n_values = 0;
		n_checked = 0;
		n_errors = 0;
		clear_decoder();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows first, under the first idle profile
		for (k = 0; k < N_DIRECTED; k++) stim_q.push_back(DIRECTED[k]);
		n_planned += N_DIRECTED;
		run_phase(23, 64);
		run_phase(64, 23);
		run_phase(0, 0);

		// drain outstanding results, then watch for strays
		while (want_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (want_q.size() != 0) n_errors++;
		$display("fed %0d bytes in %0d values over three idle profiles", n_accepted, n_values);
		$display("compared %0d decoded results, %0d errors", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#4000000;
		$display("timeout waiting on the decoder");
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/qhd_pkg.sv
hdl/qhd_decode.sv
hdl/qhd_emit.sv
hdl/quoted_hex_escape_decoder.sv
dv/testbench.sv
